// ===== rtl/lcgr_pkg.sv =====
// Shared types and constants for the range-limited LCG random number block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lcgr_pkg;

   localparam logic [31:0] LCG_MULT  = 32'd1103515245;
   localparam logic [31:0] LCG_INC   = 32'd12345;
   localparam int          STATE_W   = 31;
   localparam int          SPAN_W    = 33;
   localparam int          STEP_W    = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STATE_W - 1);

   typedef struct packed {
      logic signed [31:0] range_min;
      logic signed [31:0] range_max;
   } req_type;

   typedef struct packed {
      logic signed [31:0] random_value;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [SPAN_W-1:0]  span;
      logic [31:0]        range_min;
      logic               range_error;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/lcg_random_in_range.sv =====
// Range-limited LCG random number generator, top level.
// A range error skips the modulo steps and goes straight to the output register.
// The 31-step bit-serial modulo unit works on one word at a time.
// The queue holds QUEUE_DEPTH requests ahead of the modulo unit.
// Reset clears the generator state to zero and empties the queue and output.
// Depends on lcgr_pkg, lcgr_front, lcgr_queue and lcgr_back.
`default_nettype none

module lcg_random_in_range #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lcgr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lcgr_pkg::rsp_type       rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data
);

   lcgr_pkg::entry_type wr_entry;
   lcgr_pkg::entry_type rd_entry;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   lcgr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push),
      .entry       (wr_entry)
   );

   lcgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_entry),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .rd_data (rd_entry)
   );

   lcgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .entry       (rd_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("divider took an entry from an empty queue");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && queue_empty))
      else $error("output or queue not empty after reset");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !queue_empty)
      else $error("queue lost a pushed entry");
`endif

endmodule

`default_nettype wire

// ===== rtl/lcgr_front.sv =====
// Front end: accepts request words, advances or loads the generator state and
// classifies the range. Depends on lcgr_pkg.
`default_nettype none

module lcgr_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lcgr_pkg::req_type   req_data,
   input  wire logic                csr_wr_en,
   input  wire logic [31:0]         csr_wr_data,
   input  wire logic                queue_full,
   output logic                     push,
   output lcgr_pkg::entry_type      entry
);

   logic [31:0] state_ff;
   logic [31:0] state_in;
   logic [31:0] product;
   logic [31:0] next_raw;
   logic [33:0] span_wide;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign product  = state_ff * lcgr_pkg::LCG_MULT;
   assign next_raw = product + lcgr_pkg::LCG_INC;

   assign span_wide = {{2{req_data.range_max[31]}}, req_data.range_max}
                    - {{2{req_data.range_min[31]}}, req_data.range_min}
                    + 34'd1;

   always_comb begin
      state_in = state_ff;
      if (csr_wr_en) begin
         state_in = csr_wr_data;
      end else if (push) begin
         state_in = {1'b0, next_raw[lcgr_pkg::STATE_W-1:0]};
      end
   end

   always_comb begin
      entry.state       = next_raw[lcgr_pkg::STATE_W-1:0];
      entry.span        = span_wide[lcgr_pkg::SPAN_W-1:0];
      entry.range_min   = req_data.range_min;
      entry.range_error = span_wide[33] || (span_wide == 34'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcgr_queue.sv =====
// Short queue between the front end and the divider.
// Depends on lcgr_pkg for the entry type.
`default_nettype none

module lcgr_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lcgr_pkg::entry_type  wr_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output lcgr_pkg::entry_type       rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lcgr_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lcgr_back.sv =====
// Back end: bit-serial restoring modulo of the state by the range span,
// offset by the minimum, into the output register. Depends on lcgr_pkg.
`default_nettype none

module lcgr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_empty,
   input  wire lcgr_pkg::entry_type  entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lcgr_pkg::rsp_type         rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } fsm_type;

   fsm_type                          fsm_ff;
   fsm_type                          fsm_in;
   logic [lcgr_pkg::STATE_W-1:0]     dividend_ff;
   logic [lcgr_pkg::STATE_W-1:0]     dividend_in;
   logic [31:0]                      rem_ff;
   logic [31:0]                      rem_in;
   logic [lcgr_pkg::SPAN_W-1:0]      span_ff;
   logic [lcgr_pkg::SPAN_W-1:0]      span_in;
   logic [31:0]                      min_ff;
   logic [31:0]                      min_in;
   logic                             error_ff;
   logic                             error_in;
   logic [lcgr_pkg::STEP_W-1:0]      step_ff;
   logic [lcgr_pkg::STEP_W-1:0]      step_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   lcgr_pkg::rsp_type                rsp_data_ff;
   lcgr_pkg::rsp_type                rsp_data_in;

   logic [lcgr_pkg::SPAN_W-1:0]      trial;
   logic [lcgr_pkg::SPAN_W-1:0]      diff;
   logic                             out_free;
   logic                             load_out;

   assign trial    = {rem_ff, dividend_ff[lcgr_pkg::STATE_W-1]};
   assign diff     = trial - span_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (fsm_ff == ST_IDLE) && !queue_empty;
   assign load_out = (fsm_ff == ST_DONE) && out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      fsm_in      = fsm_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      span_in     = span_ff;
      min_in      = min_ff;
      error_in    = error_ff;
      step_in     = step_ff;
      case (fsm_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               dividend_in = entry.state;
               rem_in      = 32'd0;
               span_in     = entry.span;
               min_in      = entry.range_min;
               error_in    = entry.range_error;
               step_in     = lcgr_pkg::LAST_STEP;
               fsm_in      = entry.range_error ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in      = (trial >= span_ff) ? diff[31:0] : trial[31:0];
            dividend_in = {dividend_ff[lcgr_pkg::STATE_W-2:0], 1'b0};
            step_in     = step_ff - lcgr_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               fsm_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.random_value = error_ff ? min_ff : rem_ff + min_ff;
         rsp_data_in.range_error  = error_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      span_ff     <= span_in;
      min_ff      <= min_in;
      error_ff    <= error_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/lcg_random_in_range_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lcg_random_in_range: predicts each seeded draw and its range
// error, and compares them with the block's output words under random valid/stall timing.
// Depends on lcgr_pkg and the lcg_random_in_range RTL.

module lcg_random_in_range_tb;

   localparam logic [31:0] DRAW_MULT  = 32'd1103515245;
   localparam logic [31:0] DRAW_INC   = 32'd12345;
   localparam logic [31:0] INT_MIN    = 32'h8000_0000;
   localparam logic [31:0] INT_MAX    = 32'h7FFF_FFFF;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          TAIL_WAIT  = 40;
   localparam int          PHASE_LEN  = 115;

   class range_draw_scoreboard;
      logic [31:0]       gen_state = '0;
      lcgr_pkg::rsp_type expected_draws[$];
      int                mismatches = 0;
      int                checked = 0;
      int                range_errors = 0;

      function void load_seed(logic [31:0] seed);
         gen_state = seed;
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction

      function lcgr_pkg::rsp_type predict_draw(lcgr_pkg::req_type w);
         lcgr_pkg::rsp_type r;
         logic [31:0]       nxt;
         longint            lo;
         longint            hi;
         longint            span;
         nxt = gen_state * DRAW_MULT + DRAW_INC;
         nxt[31] = 1'b0;
         gen_state = nxt;
         lo = $signed(w.range_min);
         hi = $signed(w.range_max);
         span = hi - lo + 1;
         if (span <= 0) begin
            r.random_value = w.range_min;
            r.range_error = 1'b1;
         end else begin
            r.random_value = 32'(longint'(nxt) % span + lo);
            r.range_error = 1'b0;
         end
         return r;
      endfunction

      function void note_request(lcgr_pkg::req_type w);
         lcgr_pkg::rsp_type r;
         r = predict_draw(w);
         if (r.range_error) range_errors++;
         expected_draws.push_back(r);
      endfunction

      function void check_draw(lcgr_pkg::rsp_type got);
         lcgr_pkg::rsp_type want;
         if (expected_draws.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected word: value %0d error %b", got.random_value,
                        got.range_error);
            mismatches++;
            return;
         end
         want = expected_draws.pop_front();
         checked++;
         if (got.random_value !== want.random_value || got.range_error !== want.range_error)
         begin
            if (mismatches < 10)
               $display("draw %0d: expected value %0d error %b, got value %0d error %b",
                        checked, want.random_value, want.range_error,
                        got.random_value, got.range_error);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   lcgr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   lcgr_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [31:0]       csr_wr_data;

   range_draw_scoreboard sb = new();
   bit                   quiet = 1'b0;
   int                   words_sent = 0;
   int                   seeds_loaded = 0;
   int                   idle_cycles = 0;

   lcg_random_in_range u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_wait();
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   task automatic send_word(input logic [31:0] lo, input logic [31:0] hi);
      lcgr_pkg::req_type w;
      int                gap;
      w.range_min = lo;
      w.range_max = hi;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic wait_for_draws();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic load_seed_reg(input logic [31:0] seed);
      csr_wr_en <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.load_seed(seed);
      seeds_loaded++;
   endtask

   task automatic send_random_word();
      logic [31:0] lo;
      logic [31:0] hi;
      int          pick;
      pick = $urandom_range(0, 9);
      lo = $urandom;
      if (pick <= 3) begin
         hi = lo + 32'($urandom_range(0, 255));
      end else if (pick <= 5) begin
         hi = $urandom;
      end else if (pick == 6) begin
         lo = INT_MIN + 32'($urandom_range(0, 3));
         hi = INT_MAX - 32'($urandom_range(0, 3));
      end else if (pick == 7) begin
         hi = lo - 32'($urandom_range(1, 1000));
      end else if (pick == 8) begin
         hi = lo;
      end else begin
         lo = 32'($urandom_range(0, 200)) - 32'd100;
         hi = lo + 32'($urandom_range(0, 300));
      end
      send_word(lo, hi);
   endtask

   // receiver: hold stall for a drawn number of cycles while a word is shown
   initial begin
      int hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               sb.check_draw(rsp_data);
               hold = pick_wait();
               rsp_stall <= (hold != 0);
            end else if (rsp_valid && hold > 0) begin
               hold--;
               if (hold == 0) rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("lcg_random_in_range: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] seeds[6];
      int          phase;
      int          k;
      seeds[0] = 32'h0000_0000;
      seeds[1] = 32'hFFFF_FFFF;
      seeds[2] = INT_MAX;
      seeds[3] = $urandom;
      seeds[4] = $urandom;
      seeds[5] = $urandom;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(INT_MIN, INT_MAX);
      send_word(32'd0, 32'd0);
      send_word(INT_MAX, INT_MAX);
      send_word(INT_MIN, INT_MIN);
      send_word(32'd1, 32'd0);
      send_word(INT_MAX, INT_MIN);
      send_word(32'd0, 32'hFFFF_FFFF);
      send_word(-32'sd10, 32'd10);
      send_word(INT_MIN, 32'hFFFF_FFFF);
      send_word(32'd0, INT_MAX);
      send_word(32'hFFFF_FFFF, 32'd0);
      send_word(INT_MIN, INT_MIN + 32'd1);
      send_word(INT_MAX - 32'd1, INT_MAX);
      send_word(32'd100, 32'd50);
      wait_for_draws();
      load_seed_reg(32'hFFFF_FFFF);
      send_word(32'd0, INT_MAX);
      send_word(INT_MIN, INT_MAX);
      send_word(32'd0, 32'd9);
      wait_for_draws();
      load_seed_reg(INT_MIN);
      send_word(INT_MIN, INT_MAX);
      send_word(32'd5, 32'd5);
      wait_for_draws();

      for (phase = 0; phase < 6; phase++) begin
         load_seed_reg(seeds[phase]);
         for (k = 0; k < PHASE_LEN; k++) begin
            if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 49) == 0) wait_for_draws();
            send_random_word();
         end
         wait_for_draws();
      end
      quiet = 1'b0;

      repeat (TAIL_WAIT) @(posedge clock);
      $display("sent %0d requests over %0d seed loads; checked %0d draws, %0d range errors",
               words_sent, seeds_loaded, sb.checked, sb.range_errors);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("lcg_random_in_range: match");
      end else begin
         $display("%0d mismatches, %0d draws still expected", sb.mismatches, sb.pending());
         $display("lcg_random_in_range: mismatch");
      end
      $finish;
   end

endmodule
